FILE: src/blmc_pkg.sv
// Shared types and constants for the button LED mode controller.
// No dependencies.
package blmc_pkg;

  localparam int unsigned CntW = 16;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [1:0]      mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_BLINK        = 2'd1,
    REG_PULSE_ON     = 2'd2,
    REG_PULSE_PERIOD = 2'd3
  } reg_idx_t;

  // Mode codes
  localparam mode_t MODE_NONE   = 2'd0;
  localparam mode_t MODE_MANUAL = 2'd1;
  localparam mode_t MODE_BLINK  = 2'd2;
  localparam mode_t MODE_PULSE  = 2'd3;

  localparam cnt_t PRESS_SAT = 16'd65000;

  localparam cnt_t LONG_PRESS_RST   = 16'd300;
  localparam cnt_t BLINK_RST        = 16'd10;
  localparam cnt_t PULSE_ON_RST     = 16'd10;
  localparam cnt_t PULSE_PERIOD_RST = 16'd100;

endpackage

FILE: src/button_led_mode_controller.sv
// Button LED mode controller: one tick per request, one result per tick.
// Depends on blmc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one tick with the button
//   level on button_down. Output channel (out_valid / out_stall) returns the
//   LED drive, the mode and the release flags for that tick.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes the four timing registers; cfg_ready is always high. Write only
//   while no tick is in flight.
// Result register and throughput:
//   A tick accepted at one edge has its result loaded at that same edge; the
//   result can leave at the next edge.
//   One tick per cycle is sustained while out_stall is low: the whole update
//   is a few 16-bit compares and counter increments between the state
//   registers and the single result register.
// Stall:
//   The result register holds while out_stall is high; in_stall rises only
//   when that register is full and stalled, so a tick is taken in the same
//   cycle the previous result leaves.
// Reset:
//   rst (synchronous) restores register defaults, mode 1, LED lit, counters
//   cleared, and empties the result register.
module button_led_mode_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 button_down,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 led_lit,
  output blmc_pkg::mode_t      current_mode,
  output logic                 long_release,
  output logic                 short_release,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  blmc_pkg::reg_idx_t   cfg_index,
  input  blmc_pkg::cnt_t       cfg_data
);
  import blmc_pkg::*;

  cnt_t  long_press_ticks, blink_ticks, pulse_on_ticks, pulse_period_ticks;

  logic  lit, manual_on, held;
  mode_t active_mode;
  cnt_t  press_count, tick_count;

  logic  lit_next, manual_on_next, held_next;
  mode_t active_mode_next;
  cnt_t  press_count_next, tick_count_next;
  logic  long_rel, short_rel;

  logic  in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks   <= LONG_PRESS_RST;
      blink_ticks        <= BLINK_RST;
      pulse_on_ticks     <= PULSE_ON_RST;
      pulse_period_ticks <= PULSE_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONG_PRESS:   long_press_ticks   <= cfg_data;
        REG_BLINK:        blink_ticks        <= cfg_data;
        REG_PULSE_ON:     pulse_on_ticks     <= cfg_data;
        REG_PULSE_PERIOD: pulse_period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick update
  always_comb begin
    cnt_t tick_mid;
    lit_next         = lit;
    manual_on_next   = manual_on;
    held_next        = held;
    active_mode_next = active_mode;
    press_count_next = press_count;
    long_rel         = 1'b0;
    short_rel        = 1'b0;
    tick_mid         = tick_count;

    if (button_down) begin
      if (!held) begin
        held_next        = 1'b1;
        press_count_next = '0;
      end else if (press_count < PRESS_SAT) begin
        press_count_next = press_count + cnt_t'(1);
      end
    end else if (held) begin
      held_next = 1'b0;
      if (press_count > long_press_ticks) begin
        long_rel = 1'b1;
        tick_mid = '0;
        unique case (active_mode)
          MODE_MANUAL: begin
            active_mode_next = MODE_BLINK;
            lit_next         = 1'b0;
          end
          MODE_BLINK: begin
            active_mode_next = MODE_PULSE;
            lit_next         = 1'b1;
          end
          default: begin
            // pulse, and the unreachable zero code, go back to manual
            active_mode_next = MODE_MANUAL;
            lit_next         = 1'b1;
            manual_on_next   = 1'b1;
          end
        endcase
      end else begin
        short_rel = 1'b1;
        if (active_mode == MODE_MANUAL) begin
          manual_on_next = ~manual_on;
          lit_next       = ~manual_on;
        end
      end
    end

    // Mode action on the updated mode and tick count
    if (active_mode_next == MODE_BLINK) begin
      if (tick_mid >= blink_ticks) begin
        lit_next = ~lit_next;
        tick_mid = '0;
      end
    end else if (active_mode_next == MODE_PULSE) begin
      priority if (tick_mid == pulse_on_ticks) begin
        lit_next = 1'b0;
      end else if (tick_mid >= pulse_period_ticks) begin
        lit_next = 1'b1;
        tick_mid = '0;
      end
    end

    tick_count_next = tick_mid + cnt_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit         <= 1'b1;
      manual_on   <= 1'b1;
      held        <= 1'b0;
      active_mode <= MODE_MANUAL;
      press_count <= '0;
      tick_count  <= '0;
    end else if (in_accept) begin
      lit         <= lit_next;
      manual_on   <= manual_on_next;
      held        <= held_next;
      active_mode <= active_mode_next;
      press_count <= press_count_next;
      tick_count  <= tick_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      led_lit       <= lit_next;
      current_mode  <= active_mode_next;
      long_release  <= long_rel;
      short_release <= short_rel;
    end
  end

  // Checks
  a_release_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(long_release && short_release))
    else $error("long and short release flagged together");

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> current_mode != MODE_NONE)
    else $error("result carries mode zero");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid && current_mode == $past(active_mode_next))
    else $error("accepted tick produced no matching result");

  a_long_advances: assert property (@(posedge clk) disable iff (rst)
    in_accept && long_rel |=> active_mode != $past(active_mode))
    else $error("long release did not change mode");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

FILE: sim/tb_button_led_mode_controller.sv
`timescale 1ns / 1ps
// Self-checking bench for button_led_mode_controller: a table of directed ticks and register
// writes, then random presses, each result checked against a lamp predictor or pinned value.
// Depends on blmc_pkg and the controller RTL.
module tb_button_led_mode_controller;
  import blmc_pkg::*;

  typedef struct packed {
    logic  led;
    mode_t mode;
    logic  long_rel;
    logic  short_rel;
  } lamp_t;

  localparam bit STEP_TICK = 1'b0;
  localparam bit STEP_CFG  = 1'b1;
  localparam int NumSteps  = 25;

  typedef struct {
    bit          kind;
    reg_idx_t    idx;
    cnt_t        data;
    logic        level;
    int unsigned reps;
    bit          pinned;
    lamp_t       res;
  } step_t;

  logic     clk;
  logic     rst           = 1'b1;
  logic     in_valid      = 1'b0;
  logic     in_stall;
  logic     button_down   = 1'b0;
  logic     out_valid;
  logic     out_stall     = 1'b0;
  logic     led_lit;
  mode_t    current_mode;
  logic     long_release;
  logic     short_release;
  logic     cfg_valid     = 1'b0;
  logic     cfg_ready;
  reg_idx_t cfg_index     = REG_LONG_PRESS;
  cnt_t     cfg_data      = '0;

  // typed-in expectation that travels with a request
  bit    pinned_on  = 1'b0;
  lamp_t pinned_res = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_req = 0;
  int unsigned n_errors    = 0;

  lamp_t lamp_expect_q[$];
  step_t dir_steps[NumSteps];

  // predictor copy of the timing registers and the lamp state
  cnt_t  lp_long_press, lp_blink, lp_pulse_on, lp_pulse_period;
  logic  st_lit, st_manual, st_held;
  mode_t st_mode;
  cnt_t  st_press, st_tick;

  button_led_mode_controller i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .button_down  (button_down),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .led_lit      (led_lit),
    .current_mode (current_mode),
    .long_release (long_release),
    .short_release(short_release),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic lamp_t advance_lamp(input logic down);
    lamp_t r;
    r = '0;
    if (down) begin
      if (!st_held) begin
        st_held  = 1'b1;
        st_press = '0;
      end else if (st_press < PRESS_SAT) begin
        st_press = st_press + 1'b1;
      end
    end else if (st_held) begin
      if (st_press > lp_long_press) begin
        r.long_rel = 1'b1;
        case (st_mode)
          MODE_MANUAL: st_mode = MODE_BLINK;
          MODE_BLINK:  st_mode = MODE_PULSE;
          default:     st_mode = MODE_MANUAL;
        endcase
        case (st_mode)
          MODE_MANUAL: begin
            st_lit    = 1'b1;
            st_manual = 1'b1;
          end
          MODE_BLINK: st_lit = 1'b0;
          default:    st_lit = 1'b1;
        endcase
        st_tick = '0;
      end else begin
        r.short_rel = 1'b1;
        if (st_mode == MODE_MANUAL) begin
          st_manual = ~st_manual;
          st_lit    = st_manual;
        end
      end
      st_held = 1'b0;
    end

    if (st_mode == MODE_BLINK) begin
      if (st_tick >= lp_blink) begin
        st_lit  = ~st_lit;
        st_tick = '0;
      end
    end else if (st_mode == MODE_PULSE) begin
      // the turn-off compare wins when both match
      if (st_tick == lp_pulse_on) begin
        st_lit = 1'b0;
      end else if (st_tick >= lp_pulse_period) begin
        st_lit  = 1'b1;
        st_tick = '0;
      end
    end
    st_tick = st_tick + 1'b1;

    r.led  = st_lit;
    r.mode = st_mode;
    return r;
  endfunction

  always @(posedge clk) begin
    lamp_t got, want;
    bit    bad;
    if (rst) begin
      lp_long_press   = LONG_PRESS_RST;
      lp_blink        = BLINK_RST;
      lp_pulse_on     = PULSE_ON_RST;
      lp_pulse_period = PULSE_PERIOD_RST;
      st_lit          = 1'b1;
      st_manual       = 1'b1;
      st_held         = 1'b0;
      st_mode         = MODE_MANUAL;
      st_press        = '0;
      st_tick         = '0;
      lamp_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LONG_PRESS: lp_long_press   = cfg_data;
          REG_BLINK:      lp_blink        = cfg_data;
          REG_PULSE_ON:   lp_pulse_on     = cfg_data;
          default:        lp_pulse_period = cfg_data;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{led_lit, current_mode, long_release, short_release};
        if (lamp_expect_q.size() == 0) begin
          $error("result with no request pending: led_lit=%0d current_mode=%0d",
                 got.led, got.mode);
          n_errors++;
        end else begin
          want = lamp_expect_q.pop_front();
          bad  = 1'b0;
          if (got.led !== want.led) begin
            $error("led_lit: expected %0d, got %0d", want.led, got.led);
            bad = 1'b1;
          end
          if (got.mode !== want.mode) begin
            $error("current_mode: expected %0d, got %0d", want.mode, got.mode);
            bad = 1'b1;
          end
          if (got.long_rel !== want.long_rel) begin
            $error("long_release: expected %0d, got %0d", want.long_rel, got.long_rel);
            bad = 1'b1;
          end
          if (got.short_rel !== want.short_rel) begin
            $error("short_release: expected %0d, got %0d", want.short_rel, got.short_rel);
            bad = 1'b1;
          end
          if (bad) n_errors++;
        end
      end
      if (in_valid && !in_stall) begin
        want = advance_lamp(button_down);
        if (pinned_on) want = pinned_res;
        lamp_expect_q.push_back(want);
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked for one
  initial begin
    int unsigned hold_n;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold_n      = rx_hold_req;
        rx_hold_req = 0;
        out_stall <= 1'b1;
        repeat (hold_n) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_tick(input logic level, input bit pin, input lamp_t res);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    button_down <= level;
    pinned_on   <= pin;
    pinned_res  <= res;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off new requests until every pending result has left
  task automatic wait_settled();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (lamp_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input cnt_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic cnt_t pick_timing(input int unsigned span);
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return cnt_t'($urandom_range(1, span));
    endcase
  endfunction

  // mostly well-formed presses around the threshold, some random noise
  task automatic run_presses(input int unsigned n);
    int unsigned done_n, len, gap, cap;
    done_n = 0;
    cap    = (lp_long_press > 40) ? 44 : lp_long_press + 4;
    while (done_n < n) begin
      if ($urandom_range(99) < 15) begin
        len = $urandom_range(1, 4);
        repeat (len) send_tick(1'($urandom_range(1)), 1'b0, '0);
        done_n += len;
      end else begin
        len = $urandom_range(1, cap);
        gap = $urandom_range(0, 25);
        repeat (len) send_tick(1'b1, 1'b0, '0);
        repeat (gap + 1) send_tick(1'b0, 1'b0, '0);
        done_n += len + gap + 1;
      end
    end
  endtask

  initial begin
    int unsigned ph, k, spin;
    dir_steps = '{
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 1, 1'b1, '{1'b1, MODE_MANUAL, 1'b0, 1'b0}},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b1, 1, 1'b1, '{1'b1, MODE_MANUAL, 1'b0, 1'b0}},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 1, 1'b1, '{1'b0, MODE_MANUAL, 1'b0, 1'b1}},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b1, 1, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 1, 1'b1, '{1'b1, MODE_MANUAL, 1'b0, 1'b1}},
      '{STEP_CFG, REG_LONG_PRESS, 16'd0, 1'b0, 1, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b1, 2, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 1, 1'b1, '{1'b0, MODE_BLINK, 1'b1, 1'b0}},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 2, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b1, 1, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 1, 1'b0, '0},
      '{STEP_CFG, REG_BLINK, 16'd0, 1'b0, 1, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 3, 1'b0, '0},
      '{STEP_CFG, REG_BLINK, 16'hFFFF, 1'b0, 1, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b1, 2, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 1, 1'b1, '{1'b1, MODE_PULSE, 1'b1, 1'b0}},
      '{STEP_CFG, REG_PULSE_ON, 16'd2, 1'b0, 1, 1'b0, '0},
      '{STEP_CFG, REG_PULSE_PERIOD, 16'd2, 1'b0, 1, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 4, 1'b0, '0},
      '{STEP_CFG, REG_PULSE_ON, 16'hFFFF, 1'b0, 1, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b1, 2, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 1, 1'b1, '{1'b1, MODE_MANUAL, 1'b1, 1'b0}},
      '{STEP_CFG, REG_LONG_PRESS, 16'hFFFF, 1'b0, 1, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b1, 1, 1'b0, '0},
      '{STEP_TICK, REG_LONG_PRESS, '0, 1'b0, 1, 1'b1, '{1'b0, MODE_MANUAL, 1'b0, 1'b1}}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 14;
    rx_idle_pct = 70;
    for (int s = 0; s < NumSteps; s++) begin
      if (dir_steps[s].kind == STEP_CFG) begin
        wait_settled();
        write_reg(dir_steps[s].idx, dir_steps[s].data);
      end else begin
        repeat (dir_steps[s].reps)
          send_tick(dir_steps[s].level, dir_steps[s].pinned, dir_steps[s].res);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 14;
          rx_idle_pct = 70;
        end
        1: begin
          tx_idle_pct = 70;
          rx_idle_pct = 14;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (k = 0; k < 3; k++) begin
        wait_settled();
        write_reg(REG_LONG_PRESS, pick_timing(20));
        write_reg(REG_BLINK, pick_timing(12));
        write_reg(REG_PULSE_ON, pick_timing(15));
        write_reg(REG_PULSE_PERIOD, pick_timing(25));
        // stall the output long enough for the input side to back up
        if (k == 1 && ph != 2) rx_hold_req = 120;
        run_presses(172);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    for (spin = 0; spin < 2000 && lamp_expect_q.size() != 0; spin++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (lamp_expect_q.size() != 0) begin
      $error("%0d results never arrived", lamp_expect_q.size());
      n_errors += lamp_expect_q.size();
    end
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
